// ===== rtl/rrp_pkg.sv =====
`timescale 1ns / 1ps

package rrp_pkg;

   // Register indexes on the configuration channel.
   localparam logic [7:0] CSR_IDX_TARGET = 8'd0;
   localparam logic [7:0] CSR_IDX_GAIN   = 8'd1;

   localparam logic [15:0] TARGET_RESET  = 16'h0A00;
   localparam logic [11:0] GAIN_RESET    = 12'd2011;
   localparam logic [15:0] SPAD_FALLBACK = 16'h8000;
   localparam logic [15:0] MAX16         = 16'hFFFF;

   // Raw range status codes that the decoder recognizes.
   localparam logic [7:0] RAW_HW_CONT    = 8'd1;
   localparam logic [7:0] RAW_HW_WDOG    = 8'd2;
   localparam logic [7:0] RAW_HW_PLL     = 8'd3;
   localparam logic [7:0] RAW_SIGNAL     = 8'd4;
   localparam logic [7:0] RAW_BOUNDS     = 8'd5;
   localparam logic [7:0] RAW_SIGMA      = 8'd6;
   localparam logic [7:0] RAW_WRAP       = 8'd7;
   localparam logic [7:0] RAW_MINCLIP    = 8'd8;
   localparam logic [7:0] RAW_COMPLETE   = 8'd9;
   localparam logic [7:0] RAW_XTALK      = 8'd12;
   localparam logic [7:0] RAW_MINRANGE   = 8'd13;
   localparam logic [7:0] RAW_HW_PROC    = 8'd17;
   localparam logic [7:0] RAW_SYNC       = 8'd18;

   // Dense status codes on the result channel.
   typedef enum logic [3:0] {
      ST_VALID    = 4'd0,
      ST_SIGMA    = 4'd1,
      ST_SIGNAL   = 4'd2,
      ST_MINCLIP  = 4'd3,
      ST_BOUNDS   = 4'd4,
      ST_HARDWARE = 4'd5,
      ST_NOWRAP   = 4'd6,
      ST_WRAP     = 4'd7,
      ST_XTALK    = 4'd8,
      ST_SYNC     = 4'd9,
      ST_MINRANGE = 4'd10,
      ST_NONE     = 4'd11
   } rrp_status_type;

   // Divider: quotient bits retired per cycle and the last iteration index of each pass.
   localparam int BITS_PER_CYCLE = 4;
   localparam logic [2:0] DIV1_LAST = 3'(32 / BITS_PER_CYCLE - 1);
   localparam logic [2:0] DIV2_LAST = 3'(16 / BITS_PER_CYCLE - 1);

   // One classified measurement on its way from front to back.
   typedef struct packed {
      logic [15:0] range_corr;
      logic [3:0]  status_code;
      logic [15:0] spad_count;
      logic [15:0] total_rate;
      logic [15:0] peak_rate;
      logic [15:0] ambient_rate;
   } rrp_job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV1,
      BACK_DIV2,
      BACK_DONE
   } rrp_back_state_type;

   typedef struct packed {
      logic job_pop;
      logic out_load;
   } rrp_back_ctrl_type;

endpackage

// ===== rtl/rrp_ifs.sv =====
`timescale 1ns / 1ps

interface rrp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  raw_status;
   logic [7:0]  stream_ctr;
   logic [15:0] spad_count;
   logic [15:0] ambient_rate;
   logic [15:0] peak_rate;
   logic [15:0] raw_range;

   modport source (output valid, raw_status, stream_ctr, spad_count, ambient_rate,
                   peak_rate, raw_range, input ready);
   modport sink (input valid, raw_status, stream_ctr, spad_count, ambient_rate,
                 peak_rate, raw_range, output ready);
endinterface

interface rrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] range_corr;
   logic [3:0]  status_code;
   logic [15:0] required_spads;
   logic [15:0] peak_rate_out;
   logic [15:0] ambient_rate_out;

   modport source (output valid, range_corr, status_code, required_spads, peak_rate_out,
                   ambient_rate_out, input ready);
   modport sink (input valid, range_corr, status_code, required_spads, peak_rate_out,
                 ambient_rate_out, output ready);
endinterface

interface rrp_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/rrp_front.sv =====
`timescale 1ns / 1ps

module rrp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           raw_status,
   input  logic [7:0]           stream_ctr,
   input  logic [15:0]          spad_count,
   input  logic [15:0]          ambient_rate,
   input  logic [15:0]          peak_rate,
   input  logic [15:0]          raw_range,
   input  logic [11:0]          range_gain,
   output logic                 job_valid,
   input  logic                 job_ready,
   output rrp_pkg::rrp_job_type job
);

   logic                 valid_ff, valid_in;
   rrp_pkg::rrp_job_type job_ff, job_in;
   logic [27:0]          product;
   logic [17:0]          scaled;
   logic [16:0]          total;
   logic [3:0]           status;

   always_comb begin
      unique case (raw_status)
         rrp_pkg::RAW_HW_CONT, rrp_pkg::RAW_HW_WDOG, rrp_pkg::RAW_HW_PLL,
         rrp_pkg::RAW_HW_PROC:  status = rrp_pkg::ST_HARDWARE;
         rrp_pkg::RAW_SIGNAL:   status = rrp_pkg::ST_SIGNAL;
         rrp_pkg::RAW_BOUNDS:   status = rrp_pkg::ST_BOUNDS;
         rrp_pkg::RAW_SIGMA:    status = rrp_pkg::ST_SIGMA;
         rrp_pkg::RAW_WRAP:     status = rrp_pkg::ST_WRAP;
         rrp_pkg::RAW_MINCLIP:  status = rrp_pkg::ST_MINCLIP;
         rrp_pkg::RAW_COMPLETE: status = (stream_ctr == 8'd0) ? rrp_pkg::ST_NOWRAP
                                                              : rrp_pkg::ST_VALID;
         rrp_pkg::RAW_XTALK:    status = rrp_pkg::ST_XTALK;
         rrp_pkg::RAW_MINRANGE: status = rrp_pkg::ST_MINRANGE;
         rrp_pkg::RAW_SYNC:     status = rrp_pkg::ST_SYNC;
         default:               status = rrp_pkg::ST_NONE;
      endcase
   end

   // Range times gain over 2048, rounded half up and saturated.
   assign product = 28'(raw_range) * 28'(range_gain);
   assign scaled  = 18'((29'(product) + 29'h400) >> 11);
   assign total   = 17'(peak_rate) + 17'(ambient_rate);

   assign in_ready = !valid_ff || job_ready;

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      if (in_ready) begin
         valid_in = in_valid;
         job_in.range_corr   = (scaled > 18'(rrp_pkg::MAX16)) ? rrp_pkg::MAX16
                                                              : scaled[15:0];
         job_in.status_code  = status;
         job_in.spad_count   = spad_count;
         job_in.total_rate   = total[16] ? rrp_pkg::MAX16 : total[15:0];
         job_in.peak_rate    = peak_rate;
         job_in.ambient_rate = ambient_rate;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule

// ===== rtl/rrp_queue.sv =====
`timescale 1ns / 1ps

module rrp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  rrp_pkg::rrp_job_type push_job,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output rrp_pkg::rrp_job_type pop_job
);

   rrp_pkg::rrp_job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + 2'(push) - 2'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/rrp_back.sv =====
`timescale 1ns / 1ps

module rrp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  rrp_pkg::rrp_job_type job,
   input  logic [15:0]          target_total_rate,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [15:0]          range_corr,
   output logic [3:0]           status_code,
   output logic [15:0]          required_spads,
   output logic [15:0]          peak_rate_out,
   output logic [15:0]          ambient_rate_out
);

   rrp_pkg::rrp_back_state_type state_ff, state_in;
   rrp_pkg::rrp_back_ctrl_type  ctrl;

   rrp_pkg::rrp_job_type job_ff;
   logic [32:0] rem_ff, rem_step;
   logic [31:0] dvd_ff, dvd_step;
   logic [31:0] quo_ff, quo_step;
   logic [31:0] div_ff;
   logic [2:0]  cnt_ff;
   logic [15:0] req_ff;
   logic        last_iter;

   logic        out_valid_ff;
   logic [15:0] o_range_ff, o_req_ff, o_peak_ff, o_amb_ff;
   logic [3:0]  o_status_ff;

   // Restoring division, several quotient bits per cycle.
   always_comb begin
      rem_step = rem_ff;
      dvd_step = dvd_ff;
      quo_step = quo_ff;
      for (int i = 0; i < rrp_pkg::BITS_PER_CYCLE; i++) begin
         rem_step = {rem_step[31:0], dvd_step[31]};
         dvd_step = {dvd_step[30:0], 1'b0};
         if (rem_step >= {1'b0, div_ff}) begin
            rem_step = rem_step - {1'b0, div_ff};
            quo_step = {quo_step[30:0], 1'b1};
         end else begin
            quo_step = {quo_step[30:0], 1'b0};
         end
      end
   end

   assign last_iter = (state_ff == rrp_pkg::BACK_DIV1) ? (cnt_ff == rrp_pkg::DIV1_LAST)
                                                       : (cnt_ff == rrp_pkg::DIV2_LAST);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrp_pkg::BACK_IDLE: begin
            if (job_valid) begin
               state_in = (job.spad_count == 16'd0) ? rrp_pkg::BACK_DONE
                                                    : rrp_pkg::BACK_DIV1;
            end
         end
         rrp_pkg::BACK_DIV1: begin
            if (last_iter) begin
               if (quo_step == 32'd0 || {16'd0, target_total_rate} >= quo_step) begin
                  state_in = rrp_pkg::BACK_DONE;
               end else begin
                  state_in = rrp_pkg::BACK_DIV2;
               end
            end
         end
         rrp_pkg::BACK_DIV2: begin
            if (last_iter) begin
               state_in = rrp_pkg::BACK_DONE;
            end
         end
         rrp_pkg::BACK_DONE: begin
            if (!out_valid_ff || out_ready) begin
               state_in = rrp_pkg::BACK_IDLE;
            end
         end
         default: state_in = rrp_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         rrp_pkg::BACK_IDLE: ctrl.job_pop  = 1'b1;
         rrp_pkg::BACK_DONE: ctrl.out_load = !out_valid_ff || out_ready;
         default:            ctrl = '0;
      endcase
   end

   assign job_ready = ctrl.job_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrp_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctrl.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end

      unique case (state_ff)
         rrp_pkg::BACK_IDLE: begin
            job_ff <= job;
            rem_ff <= 33'd0;
            dvd_ff <= {job.total_rate, 16'd0};
            quo_ff <= 32'd0;
            div_ff <= {16'd0, job.spad_count};
            cnt_ff <= 3'd0;
            req_ff <= rrp_pkg::SPAD_FALLBACK;
         end
         rrp_pkg::BACK_DIV1: begin
            rem_ff <= rem_step;
            dvd_ff <= dvd_step;
            quo_ff <= quo_step;
            cnt_ff <= 3'(cnt_ff + 3'd1);
            if (last_iter) begin
               // Second pass: the quotient fits 16 bits once the target is below
               // the rate per SPAD, so the remainder starts at the target itself.
               rem_ff <= {17'd0, target_total_rate};
               dvd_ff <= 32'd0;
               quo_ff <= 32'd0;
               div_ff <= quo_step;
               cnt_ff <= 3'd0;
               req_ff <= (quo_step == 32'd0) ? rrp_pkg::SPAD_FALLBACK : rrp_pkg::MAX16;
            end
         end
         rrp_pkg::BACK_DIV2: begin
            rem_ff <= rem_step;
            dvd_ff <= dvd_step;
            quo_ff <= quo_step;
            cnt_ff <= 3'(cnt_ff + 3'd1);
            if (last_iter) begin
               req_ff <= quo_step[15:0];
            end
         end
         default: begin
         end
      endcase

      if (ctrl.out_load) begin
         o_range_ff  <= job_ff.range_corr;
         o_status_ff <= job_ff.status_code;
         o_req_ff    <= req_ff;
         o_peak_ff   <= job_ff.peak_rate;
         o_amb_ff    <= job_ff.ambient_rate;
      end
   end

   assign out_valid        = out_valid_ff;
   assign range_corr       = o_range_ff;
   assign status_code      = o_status_ff;
   assign required_spads   = o_req_ff;
   assign peak_rate_out    = o_peak_ff;
   assign ambient_rate_out = o_amb_ff;

endmodule

// ===== rtl/ranging_result_postprocessor.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Payload
// req      in         raw_status, stream_ctr, spad_count, ambient_rate, peak_rate, raw_range
// rsp      out        range_corr, status_code, required_spads, peak_rate_out, ambient_rate_out
// csr      in         index (0 target_total_rate, 1 range_gain), data
//
// The front stage takes one item a cycle while the queue has room, and registers its
// status, range and rate sum. The back divider retires four quotient bits a cycle, first
// for the rate per SPAD and then, if needed, for the SPAD target; it takes no new item until
// the last has moved to the output register, so that shared divider sets the sustained rate.
// Reset is synchronous; it empties the queue and the pipeline and restores both registers.
// A stalled rsp first holds the output register; the back stage, the two-entry queue and
// the front register then take up to four more items before req stops taking transfers.
module ranging_result_postprocessor (
   input logic   clock,
   input logic   reset,
   rrp_req_if.sink   req_chan,
   rrp_rsp_if.source rsp_chan,
   rrp_csr_if.sink   csr_chan
);

   logic [15:0] target_ff;
   logic [11:0] gain_ff;

   // Configuration is always taken; an unknown index is dropped.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= rrp_pkg::TARGET_RESET;
         gain_ff   <= rrp_pkg::GAIN_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == rrp_pkg::CSR_IDX_TARGET) begin
            target_ff <= csr_chan.data;
         end else if (csr_chan.index == rrp_pkg::CSR_IDX_GAIN) begin
            gain_ff <= csr_chan.data[11:0];
         end
      end
   end

   logic                 f_valid, f_ready;
   rrp_pkg::rrp_job_type f_job;
   logic                 q_valid, q_ready;
   rrp_pkg::rrp_job_type q_job;

   rrp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_ready     (req_chan.ready),
      .raw_status   (req_chan.raw_status),
      .stream_ctr   (req_chan.stream_ctr),
      .spad_count   (req_chan.spad_count),
      .ambient_rate (req_chan.ambient_rate),
      .peak_rate    (req_chan.peak_rate),
      .raw_range    (req_chan.raw_range),
      .range_gain   (gain_ff),
      .job_valid    (f_valid),
      .job_ready    (f_ready),
      .job          (f_job)
   );

   rrp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_job   (f_job),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_job    (q_job)
   );

   rrp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (q_valid),
      .job_ready         (q_ready),
      .job               (q_job),
      .target_total_rate (target_ff),
      .out_valid         (rsp_chan.valid),
      .out_ready         (rsp_chan.ready),
      .range_corr        (rsp_chan.range_corr),
      .status_code       (rsp_chan.status_code),
      .required_spads    (rsp_chan.required_spads),
      .peak_rate_out     (rsp_chan.peak_rate_out),
      .ambient_rate_out  (rsp_chan.ambient_rate_out)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for the ranging result post-processor.
// A directed table covers the field extremes, every raw status code and the zero
// divisor cases, then items at maximum gain. A random section follows. Every result
// is checked against an in-bench predictor of the range scaling, the status
// mapping and the SPAD target division.
module tb_top;
   import rrp_pkg::*;

   typedef struct packed {
      logic [7:0]  raw_status;
      logic [7:0]  stream_ctr;
      logic [15:0] spad_count;
      logic [15:0] ambient_rate;
      logic [15:0] peak_rate;
      logic [15:0] raw_range;
   } measurement_type;

   typedef struct packed {
      logic [15:0] range_corr;
      logic [3:0]  status_code;
      logic [15:0] required_spads;
      logic [15:0] peak_rate_out;
      logic [15:0] ambient_rate_out;
   } corrected_type;

   // One row of the directed table. When has_fixed is set, the typed-in result
   // must agree with the predictor as well as with the block.
   typedef struct packed {
      measurement_type meas;
      logic            has_fixed;
      corrected_type   fixed;
   } directed_row_type;

   localparam int RANDOM_ITEMS = 1530;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic clock;
   logic reset;

   rrp_req_if req_chan ();
   rrp_rsp_if rsp_chan ();
   rrp_csr_if csr_chan ();

   ranging_result_postprocessor dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // The predictor keeps its own copy of the two registers.
   logic [15:0] model_target_rate;
   logic [11:0] model_gain;

   corrected_type corrected_queue[$];
   int            mismatch_count;
   int            cycle_count;
   bit            idle_enabled;
   bit            long_hold_request;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [3:0] map_raw_status(input logic [7:0] raw_status,
                                                 input logic [7:0] stream_ctr);
      rrp_status_type code;
      case (raw_status)
         RAW_HW_CONT, RAW_HW_WDOG, RAW_HW_PLL, RAW_HW_PROC: code = ST_HARDWARE;
         RAW_SIGNAL:   code = ST_SIGNAL;
         RAW_BOUNDS:   code = ST_BOUNDS;
         RAW_SIGMA:    code = ST_SIGMA;
         RAW_WRAP:     code = ST_WRAP;
         RAW_MINCLIP:  code = ST_MINCLIP;
         RAW_XTALK:    code = ST_XTALK;
         RAW_MINRANGE: code = ST_MINRANGE;
         RAW_SYNC:     code = ST_SYNC;
         RAW_COMPLETE: code = (stream_ctr == 8'd0) ? ST_NOWRAP : ST_VALID;
         default: code = ST_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [15:0] compute_spad_target(input logic [15:0] spad_count,
                                                       input logic [15:0] peak_rate,
                                                       input logic [15:0] ambient_rate);
      logic [16:0] rate_sum;
      logic [31:0] rate_per_spad;
      logic [31:0] needed;
      if (spad_count == 16'd0) return SPAD_FALLBACK;
      rate_sum = {1'b0, peak_rate} + {1'b0, ambient_rate};
      if (rate_sum > 17'(MAX16)) rate_sum = 17'(MAX16);
      rate_per_spad = {rate_sum[15:0], 16'd0} / {16'd0, spad_count};
      if (rate_per_spad == 32'd0) return SPAD_FALLBACK;
      needed = {model_target_rate, 16'd0} / rate_per_spad;
      if (needed > 32'(MAX16)) return MAX16;
      return needed[15:0];
   endfunction

   function automatic corrected_type predict_correction(input measurement_type meas);
      corrected_type result;
      logic [28:0]   scaled;
      scaled = (29'(meas.raw_range) * 29'(model_gain) + 29'h400) >> 11;
      result.range_corr       = (scaled > 29'(MAX16)) ? MAX16 : scaled[15:0];
      result.status_code      = map_raw_status(meas.raw_status, meas.stream_ctr);
      result.required_spads   = compute_spad_target(meas.spad_count, meas.peak_rate,
                                                    meas.ambient_rate);
      result.peak_rate_out    = meas.peak_rate;
      result.ambient_rate_out = meas.ambient_rate;
      return result;
   endfunction

   function automatic measurement_type random_measurement();
      measurement_type meas;
      logic [7:0] status_pick [12];
      status_pick = '{RAW_HW_CONT, RAW_HW_WDOG, RAW_HW_PLL, RAW_SIGNAL, RAW_BOUNDS,
                      RAW_SIGMA, RAW_WRAP, RAW_MINCLIP, RAW_COMPLETE, RAW_XTALK,
                      RAW_MINRANGE, RAW_HW_PROC};
      meas = measurement_type'(80'({$urandom, $urandom, $urandom}));
      // Most items carry a known raw status, with range complete favored.
      case ($urandom_range(0, 9))
         0, 1, 2: meas.raw_status = RAW_COMPLETE;
         3, 4, 5, 6: meas.raw_status = status_pick[$urandom_range(0, 11)];
         7: meas.raw_status = RAW_SYNC;
         default: ;
      endcase
      if ($urandom_range(0, 5) == 0) meas.stream_ctr = 8'd0;
      // Small values bring out the zero quotient and saturation branches.
      case ($urandom_range(0, 7))
         0: meas.spad_count = 16'($urandom_range(0, 3));
         1: meas.peak_rate = 16'($urandom_range(0, 3));
         2: meas.ambient_rate = 16'($urandom_range(0, 3));
         3: begin
            meas.peak_rate    = 16'($urandom_range(0, 15));
            meas.ambient_rate = 16'($urandom_range(0, 15));
         end
         default: ;
      endcase
      return meas;
   endfunction

   // Configuration writes go through the handshake; the predictor follows.
   // Valid is dropped after each write before the channel is driven again.
   task automatic write_register(input logic [7:0] index, input logic [15:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      if (index == CSR_IDX_TARGET) model_target_rate = data;
      else if (index == CSR_IDX_GAIN) model_gain = data[11:0];
      @(posedge clock);
   endtask

   // Waits until every expected result has arrived, then lets the divider
   // pipeline run out before the registers change.
   task automatic wait_until_drained();
      while (corrected_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_measurement(input measurement_type meas, input bit may_idle);
      int gap;
      if (may_idle && idle_enabled && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.raw_status   <= meas.raw_status;
      req_chan.stream_ctr   <= meas.stream_ctr;
      req_chan.spad_count   <= meas.spad_count;
      req_chan.ambient_rate <= meas.ambient_rate;
      req_chan.peak_rate    <= meas.peak_rate;
      req_chan.raw_range    <= meas.raw_range;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // The expectation is queued at the accepting edge, ahead of any result.
      corrected_queue.push_back(predict_correction(meas));
   endtask

   // Result side: random stall bursts, plus one long hold on request.
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold_request = 1'b0;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 19);
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   // Result checker, sampled at the rising edge on the settled values.
   always @(posedge clock) begin
      corrected_type actual;
      corrected_type expected;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         actual = '{rsp_chan.range_corr, rsp_chan.status_code, rsp_chan.required_spads,
                    rsp_chan.peak_rate_out, rsp_chan.ambient_rate_out};
         if (corrected_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transfer: range %0d status %0d spads %h",
                        actual.range_corr, actual.status_code, actual.required_spads);
         end else begin
            expected = corrected_queue.pop_front();
            if (actual.range_corr != expected.range_corr ||
                actual.status_code != expected.status_code ||
                actual.required_spads != expected.required_spads ||
                actual.peak_rate_out != expected.peak_rate_out ||
                actual.ambient_rate_out != expected.ambient_rate_out) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp %0d %0d %h %h %h, got %0d %0d %h %h %h",
                           expected.range_corr, expected.status_code,
                           expected.required_spads, expected.peak_rate_out,
                           expected.ambient_rate_out,
                           actual.range_corr, actual.status_code, actual.required_spads,
                           actual.peak_rate_out, actual.ambient_rate_out);
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      directed_row_type directed_rows[$];
      measurement_type  meas;
      corrected_type    predicted;
      logic [15:0]      target_settings [4];
      logic [15:0]      gain_settings [4];
      int               phase;
      int               item;

      mismatch_count    = 0;
      cycle_count       = 0;
      idle_enabled      = 1'b1;
      long_hold_request = 1'b0;
      model_target_rate = TARGET_RESET;
      model_gain        = GAIN_RESET;

      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.raw_status   <= '0;
      req_chan.stream_ctr   <= '0;
      req_chan.spad_count   <= '0;
      req_chan.ambient_rate <= '0;
      req_chan.peak_rate    <= '0;
      req_chan.raw_range    <= '0;
      csr_chan.valid        <= 1'b0;
      csr_chan.index        <= '0;
      csr_chan.data         <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at reset settings. Fixed results cover the zero divisor
      // cases, the field extremes and the valid, no-wrap, hardware and none codes.
      directed_rows = '{
         '{'{8'd9, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
           '{16'd0, ST_VALID, SPAD_FALLBACK, 16'd0, 16'd0}},
         '{'{8'd9, 8'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0}, 1'b1,
           '{16'd0, ST_NOWRAP, SPAD_FALLBACK, 16'hFFFF, 16'hFFFF}},
         '{'{8'd1, 8'd5, 16'hFFFF, 16'd0, 16'd0, 16'd2048}, 1'b1,
           '{16'd2011, ST_HARDWARE, SPAD_FALLBACK, 16'd0, 16'd0}},
         '{'{8'd2, 8'd0, 16'd1, 16'd1, 16'd0, 16'd0}, 1'b0, '0},
         '{'{8'd3, 8'hFF, 16'd256, 16'd100, 16'd200, 16'd1000}, 1'b0, '0},
         '{'{8'd17, 8'd3, 16'hFFFF, 16'd0, 16'd1, 16'd1}, 1'b1,
           '{16'd1, ST_HARDWARE, MAX16, 16'd1, 16'd0}},
         '{'{8'd4, 8'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
         '{'{8'd5, 8'd1, 16'h8000, 16'h1234, 16'h4321, 16'h7FFF}, 1'b0, '0},
         '{'{8'd6, 8'd1, 16'h0100, 16'h0080, 16'h0080, 16'd500}, 1'b0, '0},
         '{'{8'd7, 8'd1, 16'h0F00, 16'h0001, 16'h0001, 16'd3}, 1'b0, '0},
         '{'{8'd8, 8'd1, 16'h00FF, 16'h5555, 16'hAAAA, 16'hAAAA}, 1'b0, '0},
         '{'{8'd12, 8'd1, 16'd1, 16'd0, 16'd1, 16'h5555}, 1'b0, '0},
         '{'{8'd13, 8'd1, 16'h0200, 16'h0300, 16'h0400, 16'd1}, 1'b0, '0},
         '{'{8'd18, 8'd1, 16'h0C00, 16'h0010, 16'h0020, 16'd2}, 1'b0, '0},
         '{'{8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
           '{16'd0, ST_NONE, SPAD_FALLBACK, 16'd0, 16'd0}},
         '{'{8'd10, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
           '{16'd0, ST_NONE, SPAD_FALLBACK, 16'd0, 16'd0}},
         '{'{8'd255, 8'hFF, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
           '{16'd0, ST_NONE, SPAD_FALLBACK, 16'd0, 16'd0}}
      };
      foreach (directed_rows[row]) begin
         meas = directed_rows[row].meas;
         if (directed_rows[row].has_fixed) begin
            predicted = predict_correction(meas);
            if (predicted != directed_rows[row].fixed) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("directed row %0d: table %h, predictor %h", row,
                           directed_rows[row].fixed, predicted);
            end
         end
         send_measurement(meas, 1'b1);
      end
      req_chan.valid <= 1'b0;
      wait_until_drained();

      // Maximum gain, including the saturating range, plus two ignored indices.
      write_register(CSR_IDX_GAIN, 16'd4095);
      write_register(CSR_IDX_TARGET, 16'hFFFF);
      write_register(8'd2, 16'h0123);
      write_register(8'hFF, 16'hFFFF);
      send_measurement('{8'd9, 8'd1, 16'd1, 16'd0, 16'd1, 16'hFFFF}, 1'b0);
      send_measurement('{8'd9, 8'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000}, 1'b0);
      req_chan.valid <= 1'b0;
      wait_until_drained();

      // Random phases, each under its own register setting.
      target_settings = '{16'd0, 16'hFFFF, 16'h0A00, 16'h0001};
      gain_settings   = '{16'd0, 16'd2048, 16'd2011, 16'd4095};
      for (phase = 0; phase < 6; phase++) begin
         if (phase < 4) begin
            write_register(CSR_IDX_TARGET, target_settings[phase]);
            write_register(CSR_IDX_GAIN, gain_settings[phase]);
         end else begin
            write_register(CSR_IDX_TARGET, 16'($urandom));
            write_register(CSR_IDX_GAIN, 16'($urandom_range(0, 4095)));
         end
         // The last phase runs without idling on either side.
         if (phase == 5) idle_enabled = 1'b0;
         // In phase 1 the result side holds off for a long stretch so the
         // queue fills and the input stalls.
         if (phase == 1) long_hold_request = 1'b1;
         for (item = 0; item < RANDOM_ITEMS / 6; item++) begin
            send_measurement(random_measurement(), 1'b1);
            // Once, the sender pauses until every result has come back.
            if (phase == 2 && item == 100) begin
               req_chan.valid <= 1'b0;
               while (corrected_queue.size() != 0) @(posedge clock);
            end
         end
         req_chan.valid <= 1'b0;
         wait_until_drained();
      end

      if (mismatch_count == 0 && corrected_queue.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
